[rtl/core/qgi_pkg.sv]
// ----------------------------------------------------------------------------
// qgi_pkg
// Shared constants, types and the derivative term table of the attitude
// quaternion integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package qgi_pkg;

    localparam int QGI_QUAT_WIDTH = 32;
    localparam int QGI_RATE_W     = 32;
    localparam int QGI_STEP_W     = 32;
    localparam int QGI_OUT_W      = 32;
    localparam int QGI_INC_SHIFT  = 57;
    localparam int QGI_RND_SHIFT  = 56;

    localparam logic [QGI_STEP_W-1:0] QGI_STEP_RESET = 32'd4294967;

    localparam logic [1:0] QGI_AX_W = 2'd0;
    localparam logic [1:0] QGI_AX_X = 2'd1;
    localparam logic [1:0] QGI_AX_Y = 2'd2;
    localparam logic [1:0] QGI_AX_Z = 2'd3;

    localparam logic [1:0] QGI_RATE_P = 2'd0;
    localparam logic [1:0] QGI_RATE_Q = 2'd1;
    localparam logic [1:0] QGI_RATE_R = 2'd2;

    typedef struct packed {
        logic [1:0] q_idx;
        logic [1:0] r_idx;
        logic       neg;
    } qgi_term_t;

    // One product of the quaternion derivative: which attitude component,
    // which body rate, and whether it is subtracted.
    function automatic qgi_term_t qgi_term_sel(input logic [1:0] comp, input logic [1:0] term);
        qgi_term_t t;
        t = '{q_idx: QGI_AX_W, r_idx: QGI_RATE_P, neg: 1'b0};
        case ({comp, term})
            {QGI_AX_W, 2'd0}: t = '{q_idx: QGI_AX_X, r_idx: QGI_RATE_P, neg: 1'b1};
            {QGI_AX_W, 2'd1}: t = '{q_idx: QGI_AX_Y, r_idx: QGI_RATE_Q, neg: 1'b1};
            {QGI_AX_W, 2'd2}: t = '{q_idx: QGI_AX_Z, r_idx: QGI_RATE_R, neg: 1'b1};
            {QGI_AX_X, 2'd0}: t = '{q_idx: QGI_AX_W, r_idx: QGI_RATE_P, neg: 1'b0};
            {QGI_AX_X, 2'd1}: t = '{q_idx: QGI_AX_Y, r_idx: QGI_RATE_R, neg: 1'b0};
            {QGI_AX_X, 2'd2}: t = '{q_idx: QGI_AX_Z, r_idx: QGI_RATE_Q, neg: 1'b1};
            {QGI_AX_Y, 2'd0}: t = '{q_idx: QGI_AX_W, r_idx: QGI_RATE_Q, neg: 1'b0};
            {QGI_AX_Y, 2'd1}: t = '{q_idx: QGI_AX_X, r_idx: QGI_RATE_R, neg: 1'b1};
            {QGI_AX_Y, 2'd2}: t = '{q_idx: QGI_AX_Z, r_idx: QGI_RATE_P, neg: 1'b0};
            {QGI_AX_Z, 2'd0}: t = '{q_idx: QGI_AX_W, r_idx: QGI_RATE_R, neg: 1'b0};
            {QGI_AX_Z, 2'd1}: t = '{q_idx: QGI_AX_X, r_idx: QGI_RATE_Q, neg: 1'b0};
            {QGI_AX_Z, 2'd2}: t = '{q_idx: QGI_AX_Y, r_idx: QGI_RATE_P, neg: 1'b1};
            default:          t = '{q_idx: QGI_AX_W, r_idx: QGI_RATE_P, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/core/quaternion_gyro_integrate_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_gyro_integrate_unit
// Attitude quaternion integrator: one gyro word in, one normalized attitude out.
//
// The slave stream takes one word of three body rates (Q8.24 rad/s). The
// attitude (reset to identity) advances by one explicit Euler step scaled by
// the step time, each component saturates, and the four are normalized.
// The master stream gives the new attitude in Q2.30 with the zero norm flag
// in tuser. The step time is written on the cfg channel, which is always ready;
// it resets to about one millisecond. The user must write it only while idle;
// the block itself does not enforce this. The work is done by the bit-serial
// multiplier (twelve rate terms, four step scalings and four squares), the
// bit-serial square root and four bit-serial divisions. A zero norm skips
// the root and the divisions. Words are taken one at a time. A finished
// result sits in an output register, so the next word is accepted while it
// waits; if the receiver still stalls when that word is done, the block
// holds it. Reset restores identity and clears the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_gyro_integrate_unit
    import qgi_pkg::*;
#(
    parameter int QUAT_WIDTH = QGI_QUAT_WIDTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [3*QGI_RATE_W-1:0] s_tdata,   // rate_x, rate_y, rate_z
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [4*QGI_OUT_W-1:0]       m_tdata,   // att_w, att_x, att_y, att_z
    output logic [0:0]                   m_tuser,   // norm_fault
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [QGI_STEP_W-1:0]   cfg_data
);

    localparam int W   = QUAT_WIDTH;
    localparam int F   = W - 2;
    localparam int DW  = W + 34;
    localparam int M   = (W > 33) ? W : 33;
    localparam int PW  = DW + M;
    localparam int IW  = W + 10;
    localparam int RW  = W + 1;
    localparam int SSW = 2 * RW;
    localparam int NW  = W + F;

    localparam logic [W-1:0]  Q_ONE = {2'b01, {F{1'b0}}};
    localparam logic [W-1:0]  Q_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  Q_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] RND   = {{(PW-1){1'b0}}, 1'b1} << QGI_RND_SHIFT;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_TERM_GO   = 12'b000000000010,
        S_TERM_WAIT = 12'b000000000100,
        S_INC_GO    = 12'b000000001000,
        S_INC_WAIT  = 12'b000000010000,
        S_SQ_GO     = 12'b000000100000,
        S_SQ_WAIT   = 12'b000001000000,
        S_ROOT_GO   = 12'b000010000000,
        S_ROOT_WAIT = 12'b000100000000,
        S_DIV_GO    = 12'b001000000000,
        S_DIV_WAIT  = 12'b010000000000,
        S_DONE      = 12'b100000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              comp_reg, comp_next;
    logic [1:0]              term_reg, term_next;
    logic [QGI_STEP_W-1:0]   step_reg, step_next;
    logic [QGI_RATE_W-1:0]   rate_reg [3];
    logic [QGI_RATE_W-1:0]   rate_next [3];
    logic [W-1:0]            att_reg [4];
    logic [W-1:0]            att_next [4];
    logic [W-1:0]            n_reg [4];
    logic [W-1:0]            n_next [4];
    logic [DW-1:0]           d_reg, d_next;
    logic [SSW-1:0]          ss_reg, ss_next;
    logic [RW-1:0]           nrm_reg, nrm_next;
    logic                    fault_reg, fault_next;
    logic                    out_valid_reg, out_valid_next;
    logic [4*QGI_OUT_W-1:0]  out_data_reg, out_data_next;
    logic                    out_fault_reg, out_fault_next;

    qgi_term_t               tsel;
    logic [1:0]              att_idx;
    logic [W-1:0]            att_rd;
    logic [W-1:0]            n_rd;
    logic [QGI_RATE_W-1:0]   rate_rd;
    logic                    mul_start;
    logic [DW-1:0]           mul_a;
    logic [M-1:0]            mul_b;
    logic                    mul_done;
    logic [PW-1:0]           mul_p;
    logic [PW-1:0]           rounded;
    logic [IW-1:0]           inc;
    logic [IW-1:0]           sum;
    logic [W-1:0]            sat_val;
    logic                    root_start;
    logic                    root_done;
    logic [RW-1:0]           root;
    logic                    div_start;
    logic [W-1:0]            mag;
    logic                    div_done;
    logic [W-1:0]            quo;
    logic [QGI_OUT_W-1:0]    q230 [4];

    assign tsel    = qgi_term_sel(comp_reg, term_reg);
    assign att_idx = (state_reg == S_TERM_GO) ? tsel.q_idx : comp_reg;
    assign att_rd  = att_reg[att_idx];
    assign n_rd    = n_reg[comp_reg];
    assign rate_rd = rate_reg[tsel.r_idx];
    assign mag     = n_rd[W-1] ? (W'(0) - n_rd) : n_rd;

    assign rounded = mul_p + RND;
    assign inc     = rounded[QGI_INC_SHIFT +: IW];
    assign sum     = {{(IW-W){att_rd[W-1]}}, att_rd} + inc;

    always_comb
    begin
        if (sum[IW-1:W-1] == {(IW-W+1){1'b0}} || sum[IW-1:W-1] == {(IW-W+1){1'b1}})
            sat_val = sum[W-1:0];
        else if (sum[IW-1])
            sat_val = Q_MIN;
        else
            sat_val = Q_MAX;
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = {{(DW-W){att_rd[W-1]}}, att_rd};
        mul_b     = {{(M-QGI_RATE_W){rate_rd[QGI_RATE_W-1]}}, rate_rd};
        case (state_reg)
            S_TERM_GO:
            begin
                mul_start = 1'b1;
            end
            S_INC_GO:
            begin
                mul_start = 1'b1;
                mul_a     = d_reg;
                mul_b     = {{(M-QGI_STEP_W){1'b0}}, step_reg};
            end
            S_SQ_GO:
            begin
                mul_start = 1'b1;
                mul_a     = {{(DW-W){n_rd[W-1]}}, n_rd};
                mul_b     = {{(M-W){n_rd[W-1]}}, n_rd};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign root_start = (state_reg == S_ROOT_GO) && (ss_reg != '0);
    assign div_start  = (state_reg == S_DIV_GO);

    qgi_mul #(
        .AW (DW),
        .BW (M)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    qgi_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (ss_reg),
        .done     (root_done),
        .root     (root)
    );

    qgi_div #(
        .NW (NW),
        .DW (RW),
        .QW (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({mag, {F{1'b0}}}),
        .den   (nrm_reg),
        .done  (div_done),
        .quo   (quo)
    );

    generate
        for (genvar g = 0; g < 4; g++)
        begin : g_out
            if (F >= 30)
            begin : g_shr
                logic signed [W-1:0] shr;
                assign shr     = $signed(att_reg[g]) >>> (F - 30);
                assign q230[g] = shr[QGI_OUT_W-1:0];
            end
            else
            begin : g_shl
                assign q230[g] = {att_reg[g], {(30-F){1'b0}}};
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        term_next      = term_reg;
        step_next      = step_reg;
        rate_next      = rate_reg;
        att_next       = att_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        ss_next        = ss_reg;
        nrm_next       = nrm_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_fault_next = out_fault_reg;

        if (cfg_valid)
            step_next = cfg_data;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    rate_next[0] = s_tdata[0 +: QGI_RATE_W];
                    rate_next[1] = s_tdata[QGI_RATE_W +: QGI_RATE_W];
                    rate_next[2] = s_tdata[2*QGI_RATE_W +: QGI_RATE_W];
                    comp_next    = QGI_AX_W;
                    term_next    = 2'd0;
                    d_next       = '0;
                    state_next   = S_TERM_GO;
                end
            end
            S_TERM_GO:
            begin
                state_next = S_TERM_WAIT;
            end
            S_TERM_WAIT:
            begin
                if (mul_done)
                begin
                    if (tsel.neg)
                        d_next = d_reg - mul_p[DW-1:0];
                    else
                        d_next = d_reg + mul_p[DW-1:0];
                    if (term_reg == 2'd2)
                    begin
                        state_next = S_INC_GO;
                    end
                    else
                    begin
                        term_next  = term_reg + 2'd1;
                        state_next = S_TERM_GO;
                    end
                end
            end
            S_INC_GO:
            begin
                state_next = S_INC_WAIT;
            end
            S_INC_WAIT:
            begin
                if (mul_done)
                begin
                    n_next[comp_reg] = sat_val;
                    d_next           = '0;
                    term_next        = 2'd0;
                    if (comp_reg == QGI_AX_Z)
                    begin
                        comp_next  = QGI_AX_W;
                        ss_next    = '0;
                        state_next = S_SQ_GO;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_TERM_GO;
                    end
                end
            end
            S_SQ_GO:
            begin
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    ss_next = ss_reg + mul_p[SSW-1:0];
                    if (comp_reg == QGI_AX_Z)
                    begin
                        comp_next  = QGI_AX_W;
                        state_next = S_ROOT_GO;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_SQ_GO;
                    end
                end
            end
            S_ROOT_GO:
            begin
                if (ss_reg == '0)
                begin
                    att_next[0] = Q_ONE;
                    att_next[1] = '0;
                    att_next[2] = '0;
                    att_next[3] = '0;
                    fault_next  = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    fault_next = 1'b0;
                    state_next = S_ROOT_WAIT;
                end
            end
            S_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    nrm_next   = root;
                    comp_next  = QGI_AX_W;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    att_next[comp_reg] = n_rd[W-1] ? (W'(0) - quo) : quo;
                    if (comp_reg == QGI_AX_Z)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {q230[3], q230[2], q230[1], q230[0]};
                    out_fault_next = fault_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= QGI_AX_W;
            term_reg      <= 2'd0;
            step_reg      <= QGI_STEP_RESET;
            att_reg[0]    <= Q_ONE;
            att_reg[1]    <= '0;
            att_reg[2]    <= '0;
            att_reg[3]    <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            term_reg      <= term_next;
            step_reg      <= step_next;
            att_reg       <= att_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg      <= rate_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        ss_reg        <= ss_next;
        nrm_reg       <= nrm_next;
        out_data_reg  <= out_data_next;
        out_fault_reg <= out_fault_next;
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_fault_reg;
    assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

[rtl/core/qgi_mul.sv]
// ----------------------------------------------------------------------------
// qgi_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
`default_nettype none

module qgi_mul
    import qgi_pkg::*;
#(
    parameter int AW = 66,
    parameter int BW = 33
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [AW-1:0]        a,
    input  wire logic [BW-1:0]        b,
    output logic                      done,
    output logic [AW+BW-1:0]          p
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0] mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = {{BW{a[AW-1]}}, a};
            mplier_next = b;
            cnt_next    = CW'(BW);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // The top multiplier bit carries negative weight.
            if (mplier_reg[0])
            begin
                if (cnt_reg == CW'(1))
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PW-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[BW-1:1]};
            cnt_next    = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

[rtl/core/qgi_sqrt.sv]
// ----------------------------------------------------------------------------
// qgi_sqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qgi_sqrt
    import qgi_pkg::*;
#(
    parameter int RW = 33
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2*RW-1:0]   radicand,
    output logic                   done,
    output logic [RW-1:0]          root
);

    localparam int CW = $clog2(RW + 1);
    localparam int EW = RW + 4;

    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [EW-1:0]   shifted;
    logic [EW-1:0]   trial;
    logic [EW-1:0]   diff;

    always_comb
    begin
        shifted     = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
        trial       = {2'b00, root_reg, 2'b01};
        diff        = shifted - trial;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[2*RW-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = diff[RW+1:0];
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[RW+1:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[rtl/core/qgi_div.sv]
// ----------------------------------------------------------------------------
// qgi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qgi_div
    import qgi_pkg::*;
#(
    parameter int NW = 62,
    parameter int DW = 33,
    parameter int QW = 32
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [NW-1:0]   num,
    input  wire logic [DW-1:0]   den,
    output logic                 done,
    output logic [QW-1:0]        quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW+1:0] shifted;
    logic [DW+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[NW-1]};
        diff      = shifted - {2'b00, den_reg};
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (shifted >= {2'b00, den_reg})
            begin
                rem_next = diff[DW:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[tb/quaternion_gyro_integrate_unit_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_gyro_integrate_unit_tb
// Self-checking testbench for the attitude quaternion integrator. A queue of
// gyro words feeds a stream driver, a predictor mirrors the attitude state
// and the step time, and a monitor compares each attitude word field by
// field. The step time runs through several settings, extremes included,
// with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_gyro_integrate_unit_tb;

    import qgi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [31:0] ONE_Q230 = 32'sd1 << 30;

    typedef struct packed {
        logic signed [31:0] att_w;
        logic signed [31:0] att_x;
        logic signed [31:0] att_y;
        logic signed [31:0] att_z;
        logic               norm_fault;
    } attitude_word_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [3*QGI_RATE_W-1:0]     s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [4*QGI_OUT_W-1:0]      m_tdata;
    logic [0:0]                  m_tuser;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [QGI_STEP_W-1:0]       cfg_data;

    logic [3*QGI_RATE_W-1:0]     gyro_pending[$];
    attitude_word_t              attitude_expected[$];
    logic signed [31:0]          model_att[4];
    logic [31:0]                 model_step;
    logic                        gyro_taken;
    logic                        quiet;
    int                          in_idle;
    int                          out_idle;
    int                          errors;
    int                          words_checked;
    int                          saturated_seen;
    int                          stall_cycles;

    quaternion_gyro_integrate_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [63:0] saturate_q(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Advances the attitude by one Euler step and returns the normalized word.
    function automatic attitude_word_t integrate_sample(input logic signed [31:0] rx,
                                                        input logic signed [31:0] ry,
                                                        input logic signed [31:0] rz);
        logic signed [127:0] q0, q1, q2, q3, p, r, y;
        logic signed [127:0] dv[4];
        logic signed [127:0] prod;
        logic signed [127:0] nwide;
        logic signed [63:0]  inc;
        logic signed [63:0]  nv[4];
        logic [127:0]        ss;
        logic [127:0]        cand;
        logic [127:0]        mag;
        logic [127:0]        quo;
        logic [63:0]         root;
        attitude_word_t      res;
        q0 = model_att[0];
        q1 = model_att[1];
        q2 = model_att[2];
        q3 = model_att[3];
        p = rx;
        r = ry;
        y = rz;
        dv[0] = -(q1 * p + q2 * r + q3 * y);
        dv[1] = q0 * p + q2 * y - q3 * r;
        dv[2] = q0 * r - q1 * y + q3 * p;
        dv[3] = q0 * y + q1 * r - q2 * p;
        ss = '0;
        for (int i = 0; i < 4; i++)
        begin
            prod = dv[i] * $signed({96'b0, model_step}) + (128'sd1 <<< 56);
            inc = 64'(prod >>> 57);
            nv[i] = saturate_q(64'(model_att[i]) + inc);
            if (nv[i] != 64'(model_att[i]) + inc)
                saturated_seen++;
            nwide = nv[i];
            ss = ss + 128'(nwide * nwide);
        end
        if (ss == '0)
        begin
            model_att[0] = ONE_Q230;
            model_att[1] = '0;
            model_att[2] = '0;
            model_att[3] = '0;
            res.norm_fault = 1'b1;
        end
        else
        begin
            root = '0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = {64'b0, root | (64'd1 << b)};
                if (cand * cand <= ss)
                    root = cand[63:0];
            end
            for (int i = 0; i < 4; i++)
            begin
                mag = nv[i] < 0 ? 128'(-nv[i]) : 128'(nv[i]);
                quo = (mag << 30) / {64'b0, root};
                model_att[i] = nv[i] < 0 ? -$signed(quo[31:0]) : $signed(quo[31:0]);
            end
            res.norm_fault = 1'b0;
        end
        res.att_w = model_att[0];
        res.att_x = model_att[1];
        res.att_y = model_att[2];
        res.att_z = model_att[3];
        return res;
    endfunction

    function automatic logic [31:0] random_rate();
        if ($urandom_range(0, 9) < 6)
            return 32'($signed($urandom_range(0, 32'd134217728)) - 32'sd67108864);
        return $urandom;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_taken <= 1'b0;
            model_att[0] <= ONE_Q230;
            model_att[1] <= '0;
            model_att[2] <= '0;
            model_att[3] <= '0;
            model_step <= QGI_STEP_RESET;
        end
        else
        begin
            gyro_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                model_step <= cfg_data;
            if (s_tvalid && s_tready)
                attitude_expected.push_back(integrate_sample(s_tdata[31:0], s_tdata[63:32],
                                                             s_tdata[95:64]));
        end
    end

    always @(posedge clk)
    begin
        attitude_word_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (attitude_expected.size() == 0)
            begin
                $error("attitude word with no expectation waiting");
                errors++;
            end
            else
            begin
                exp_word = attitude_expected.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== exp_word.att_w)
                begin
                    $error("att_w expected %0d actual %0d", exp_word.att_w,
                           $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[63:32] !== exp_word.att_x)
                begin
                    $error("att_x expected %0d actual %0d", exp_word.att_x,
                           $signed(m_tdata[63:32]));
                    errors++;
                end
                if (m_tdata[95:64] !== exp_word.att_y)
                begin
                    $error("att_y expected %0d actual %0d", exp_word.att_y,
                           $signed(m_tdata[95:64]));
                    errors++;
                end
                if (m_tdata[127:96] !== exp_word.att_z)
                begin
                    $error("att_z expected %0d actual %0d", exp_word.att_z,
                           $signed(m_tdata[127:96]));
                    errors++;
                end
                if (m_tuser[0] !== exp_word.norm_fault)
                begin
                    $error("norm_fault expected %0d actual %0d", exp_word.norm_fault,
                           m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || gyro_taken))
        begin
            if (in_idle > 0)
            begin
                in_idle--;
                s_tvalid <= 1'b0;
            end
            else if (gyro_pending.size() == 0)
                s_tvalid <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_idle = $urandom_range(0, 11);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata <= gyro_pending.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_idle > 0)
            begin
                out_idle--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_idle = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_step_time(input logic [31:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_attitude();
        while (gyro_pending.size() != 0 || s_tvalid || attitude_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic queue_gyro(input logic [31:0] rx, input logic [31:0] ry,
                              input logic [31:0] rz);
        gyro_pending.push_back({rz, ry, rx});
    endtask

    initial
    begin
        logic [31:0] step_plan[6];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        in_idle = 0;
        out_idle = 0;
        errors = 0;
        words_checked = 0;
        saturated_seen = 0;
        stall_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at the reset step time, then at the largest step and at a zero step.
        queue_gyro(32'd0, 32'd0, 32'd0);
        queue_gyro(32'h7FFF_FFFF, 32'd0, 32'd0);
        queue_gyro(32'd0, 32'h8000_0000, 32'd0);
        queue_gyro(32'd0, 32'd0, 32'h7FFF_FFFF);
        queue_gyro(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_gyro(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_gyro(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        queue_gyro(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000);
        drain_attitude();
        write_step_time(32'hFFFF_FFFF);
        queue_gyro(32'h7FFF_FFFF, 32'd0, 32'd0);
        queue_gyro(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_gyro(32'd0, 32'd0, 32'h7FFF_FFFF);
        queue_gyro(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_gyro(32'd0, 32'd0, 32'd0);
        drain_attitude();
        write_step_time(32'd0);
        queue_gyro(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_gyro(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
        drain_attitude();

        step_plan[0] = QGI_STEP_RESET;
        step_plan[1] = 32'd0;
        step_plan[2] = 32'hFFFF_FFFF;
        step_plan[3] = $urandom;
        step_plan[4] = 32'd42949672;
        step_plan[5] = $urandom_range(1, 32'd100000);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_step_time(step_plan[ph]);
            quiet = (ph == 5);
            for (int k = 0; k < 97; k++)
                queue_gyro(random_rate(), random_rate(), random_rate());
            drain_attitude();
        end

        $display("Checked %0d attitude words over nine step time phases,", words_checked);
        $display("including zero and full scale steps; %0d components saturated.",
                 saturated_seen);
        if (errors == 0 && attitude_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
